@@ src/mrr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared constants, types and helper functions of the matrix ring rotator.
// ----------------------------------------------------------------------------
package mrr_pkg;

  localparam int MAX_DIM     = 16;
  localparam int DATA_WIDTH  = 32;

  // Fixed field widths of the ports
  localparam int COORD_W     = 4;
  localparam int COUNT_W     = 5;
  localparam int SHELL_W     = 4;
  localparam int AMT_W       = 32;
  localparam int VALUE_W     = 32;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  // Derived sizes
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int RING_DEPTH  = 4 * (MAX_DIM - 1);
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int RING_W      = $clog2(RING_DEPTH + 1);
  localparam int DIM_W       = $clog2(MAX_DIM);
  localparam int EFF_W       = $clog2(MAX_DIM + 1);
  localparam int GEO_W       = ((EFF_W > SHELL_W + 1) ? EFF_W : SHELL_W + 1) + 3;
  localparam int MCNT_W      = $clog2(AMT_W);

  typedef logic [DATA_WIDTH-1:0]   word_t;
  typedef logic signed [GEO_W-1:0] geo_t;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_ROTATE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_DEGEN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_ROWS   = 2'd0,
    REG_COLS   = 2'd1,
    REG_SHELL  = 2'd2,
    REG_AMOUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MOD,
    ST_GATHER,
    ST_GDRAIN,
    ST_SCATTER,
    ST_SDRAIN
  } state_t;

  typedef struct packed {
    logic [EFF_W-1:0]   rows;
    logic [EFF_W-1:0]   cols;
    logic [SHELL_W-1:0] shell;
    logic [AMT_W-1:0]   amount;
  } cfg_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    word_t               wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] waddr;
    word_t              wdata;
    logic               re;
    logic [RING_AW-1:0] raddr;
  } ring_req_t;

  typedef struct packed {
    logic              start;
    logic [AMT_W-1:0]  dividend;
    logic [RING_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [RING_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [STORE_AW-1:0] store_addr(input int r, input int c);
    return STORE_AW'(r * MAX_DIM + c);
  endfunction

  function automatic word_t to_word(input logic signed [VALUE_W-1:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] from_word(input logic signed [DATA_WIDTH-1:0] w);
    logic signed [63:0] ext;
    ext = 64'(w);
    return ext[VALUE_W-1:0];
  endfunction

endpackage

@@ src/mrr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mrr_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/mrr_mod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_mod
// Bit-serial remainder unit: normalizes a signed amount into 0 .. n-1.
// ----------------------------------------------------------------------------
module mrr_mod import mrr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic              act_r;
  logic              done_r;
  logic [MCNT_W-1:0] cnt_r;
  logic [AMT_W-1:0]  mag_r;
  logic              neg_r;
  logic [RING_W-1:0] div_r;
  logic [RING_W-1:0] rem_r;
  logic [RING_W-1:0] res_r;

  logic [RING_W:0]   rem_sh;
  logic [RING_W:0]   rem_sub;
  logic [RING_W-1:0] rem_nx;
  logic [RING_W-1:0] res_nx;

  // Shift in one dividend bit, subtract the divisor when it fits
  always_comb begin
    rem_sh  = {rem_r, mag_r[AMT_W-1]};
    rem_sub = rem_sh - {1'b0, div_r};
    rem_nx  = (rem_sh >= {1'b0, div_r}) ? rem_sub[RING_W-1:0] : rem_sh[RING_W-1:0];
    res_nx  = (neg_r && (rem_nx != '0)) ? (div_r - rem_nx) : rem_nx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        act_r <= 1'b1;
      end else if (act_r && (cnt_r == MCNT_W'(AMT_W - 1))) begin
        act_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= '0;
      neg_r <= req.dividend[AMT_W-1];
      mag_r <= req.dividend[AMT_W-1] ? (AMT_W'(0) - req.dividend) : req.dividend;
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (act_r) begin
      cnt_r <= cnt_r + 1'b1;
      mag_r <= {mag_r[AMT_W-2:0], 1'b0};
      rem_r <= rem_nx;
      res_r <= res_nx;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = res_r;

endmodule

@@ src/mrr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_ctrl
// Item sequencer: element access, ring walk, gather and scatter passes.
// ----------------------------------------------------------------------------
module mrr_ctrl import mrr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_action,
  input  logic [COORD_W-1:0]  in_row_index,
  input  logic [COORD_W-1:0]  in_column_index,
  input  logic [VALUE_W-1:0]  in_write_value,
  output logic                out_valid,
  output logic [VALUE_W-1:0]  out_read_value,
  output logic [1:0]          out_status,
  output store_req_t          store_req,
  input  word_t               store_rdata,
  output ring_req_t           ring_req,
  input  word_t               ring_rdata,
  output mod_req_t            mod_req,
  input  mod_rsp_t            mod_rsp
);

  state_t state_r, state_nxt;

  action_t act;
  logic    accept;
  logic    coord_ok;
  logic    degen;
  geo_t    h_c, w_c, n_c;
  logic [STORE_AW-1:0] item_addr;
  logic [STORE_AW-1:0] walk_addr;

  // Ring geometry, latched on a rotate
  logic [DIM_W-1:0]   minr_r, maxr_r, minc_r, maxc_r;
  logic [RING_W-1:0]  n_r;
  logic [RING_W-1:0]  k_r;
  logic [RING_AW-1:0] j_r;
  logic [DIM_W-1:0]   cur_r_r, cur_c_r;
  logic [DIM_W-1:0]   nxt_r, nxt_c;
  logic               last_k;
  logic [RING_AW-1:0] j_next;

  // One-stage pending write after a memory read
  logic                pend_g_r, pend_s_r;
  logic [RING_AW-1:0]  pend_ring_r;
  logic [STORE_AW-1:0] pend_store_r;

  logic                out_valid_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic [1:0]          out_status_r;

  assign act    = action_t'(in_action);
  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    coord_ok  = (int'(in_row_index) < int'(cfg.rows)) &&
                (int'(in_column_index) < int'(cfg.cols));
    item_addr = store_addr(int'(in_row_index), int'(in_column_index));
    h_c       = geo_t'(cfg.rows) - geo_t'(cfg.shell) - geo_t'(cfg.shell) + geo_t'(1);
    w_c       = geo_t'(cfg.cols) - geo_t'(cfg.shell) - geo_t'(cfg.shell) + geo_t'(1);
    n_c       = geo_t'(2) * (h_c + w_c);
    degen     = (cfg.shell == '0) || (h_c < geo_t'(1)) || (w_c < geo_t'(1)) ||
                (n_c > geo_t'(RING_DEPTH));
  end

  // Counterclockwise walk: down left wall, along bottom, up right wall, back on top
  always_comb begin
    nxt_r = cur_r_r;
    nxt_c = cur_c_r;
    if ((cur_c_r == minc_r) && (cur_r_r < maxr_r)) begin
      nxt_r = cur_r_r + 1'b1;
    end else if ((cur_r_r == maxr_r) && (cur_c_r < maxc_r)) begin
      nxt_c = cur_c_r + 1'b1;
    end else if ((cur_c_r == maxc_r) && (cur_r_r > minr_r)) begin
      nxt_r = cur_r_r - 1'b1;
    end else begin
      nxt_c = cur_c_r - 1'b1;
    end
    walk_addr = store_addr(int'(cur_r_r), int'(cur_c_r));
    last_k    = (k_r == (n_r - RING_W'(1)));
    j_next    = ((RING_W'(j_r) + RING_W'(1)) == n_r) ? '0 : (j_r + 1'b1);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((act == ACT_READ) && coord_ok) begin
            state_nxt = ST_READ;
          end else if ((act == ACT_ROTATE) && !degen) begin
            state_nxt = ST_MOD;
          end
        end
      end
      ST_READ:    state_nxt = ST_IDLE;
      ST_MOD: begin
        if (mod_rsp.done) begin
          state_nxt = ST_GATHER;
        end
      end
      ST_GATHER: begin
        if (last_k) begin
          state_nxt = ST_GDRAIN;
        end
      end
      ST_GDRAIN:  state_nxt = ST_SCATTER;
      ST_SCATTER: begin
        if (last_k) begin
          state_nxt = ST_SDRAIN;
        end
      end
      ST_SDRAIN:  state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Memory and divider requests
  always_comb begin
    store_req          = '0;
    store_req.waddr    = item_addr;
    store_req.wdata    = to_word(in_write_value);
    store_req.raddr    = item_addr;
    ring_req           = '0;
    ring_req.raddr     = RING_AW'(k_r);
    mod_req.start      = 1'b0;
    mod_req.dividend   = cfg.amount;
    mod_req.divisor    = RING_W'(n_c);
    case (state_r)
      ST_IDLE: begin
        store_req.we  = accept && (act == ACT_WRITE) && coord_ok;
        store_req.re  = accept && (act == ACT_READ) && coord_ok;
        mod_req.start = accept && (act == ACT_ROTATE) && !degen;
      end
      ST_GATHER: begin
        store_req.re    = 1'b1;
        store_req.raddr = walk_addr;
      end
      ST_SCATTER: begin
        ring_req.re = 1'b1;
      end
      default: begin
      end
    endcase
    // Land the word fetched in the previous cycle
    ring_req.we    = pend_g_r;
    ring_req.waddr = pend_ring_r;
    ring_req.wdata = store_rdata;
    if (pend_s_r) begin
      store_req.we    = 1'b1;
      store_req.waddr = pend_store_r;
      store_req.wdata = ring_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_g_r    <= 1'b0;
      pend_s_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_g_r    <= (state_r == ST_GATHER);
      pend_s_r    <= (state_r == ST_SCATTER);
      out_valid_r <= (accept && (state_nxt == ST_IDLE)) ||
                     (state_r == ST_READ) || (state_r == ST_SDRAIN);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        out_value_r <= '0;
        if ((act == ACT_WRITE || act == ACT_READ) && !coord_ok) begin
          out_status_r <= STAT_RANGE;
        end else if ((act == ACT_ROTATE) && degen) begin
          out_status_r <= STAT_DEGEN;
        end else begin
          out_status_r <= STAT_OK;
        end
        minr_r <= DIM_W'(int'(cfg.shell) - 1);
        minc_r <= DIM_W'(int'(cfg.shell) - 1);
        maxr_r <= DIM_W'(int'(cfg.rows) - int'(cfg.shell));
        maxc_r <= DIM_W'(int'(cfg.cols) - int'(cfg.shell));
        n_r    <= RING_W'(n_c);
      end
      ST_READ: begin
        out_value_r  <= from_word(store_rdata);
        out_status_r <= STAT_OK;
      end
      ST_MOD: begin
        j_r     <= RING_AW'(mod_rsp.rem);
        k_r     <= '0;
        cur_r_r <= minr_r;
        cur_c_r <= minc_r;
      end
      ST_GATHER: begin
        pend_ring_r <= j_r;
        j_r         <= j_next;
        k_r         <= k_r + 1'b1;
        cur_r_r     <= nxt_r;
        cur_c_r     <= nxt_c;
      end
      ST_GDRAIN: begin
        k_r     <= '0;
        cur_r_r <= minr_r;
        cur_c_r <= minc_r;
      end
      ST_SCATTER: begin
        pend_store_r <= walk_addr;
        k_r          <= k_r + 1'b1;
        cur_r_r      <= nxt_r;
        cur_c_r      <= nxt_c;
      end
      ST_SDRAIN: begin
        out_value_r  <= '0;
        out_status_r <= STAT_OK;
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

  // The store is only read while the ring is gathered
  a_no_store_write_in_gather: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GATHER) |-> !store_req.we)
    else $error("store written during gather");

  a_k_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GATHER || state_r == ST_SCATTER) |-> (k_r < n_r))
    else $error("ring position beyond perimeter");

  // A full lap brings the walker back to the top-left corner
  a_walk_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SDRAIN) |-> (cur_r_r == minr_r && cur_c_r == minc_r))
    else $error("ring walk did not close");

  a_mod_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (mod_rsp.rem < n_r))
    else $error("normalized amount not below perimeter");

endmodule

@@ src/matrix_ring_rotate_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_ring_rotate_core
// Matrix store with element write/read and rotation of one concentric ring.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_action/in_row_index/in_column_index/in_write_value
//   with start; a beat is taken at a clock edge where start is high and busy
//   is low. Every beat yields exactly one result beat on out_read_value and
//   out_status, strobed by out_valid for one cycle; the receiver must take it.
//   Configuration: APB registers at 0x0 row_count, 0x4 column_count,
//   0x8 shell_number, 0xC rotate_amount. Write them only while idle.
//   Sequence: write, out-of-range, degenerate ring and unused action: result
//   in the cycle after the beat, busy stays low, one beat per cycle. Read:
//   busy while the word is fetched, result registered from the store. Rotate
//   of a ring with perimeter n: wait on the bit-serial remainder unit, then
//   one pass over the n positions that copies the ring into the ring buffer
//   and one pass that writes it back, each pass followed by a drain state;
//   busy stays high until the ring is written back.
//   Reset: control clears, registers take 16/16/1/0; store contents are
//   undefined until written.
// ----------------------------------------------------------------------------
module matrix_ring_rotate_core import mrr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [COORD_W-1:0] in_row_index,
  input  logic [COORD_W-1:0] in_column_index,
  input  logic [VALUE_W-1:0] in_write_value,
  // Result channel
  output logic               out_valid,
  output logic [VALUE_W-1:0] out_read_value,
  output logic [1:0]         out_status,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  logic [COUNT_W-1:0] row_count_r;
  logic [COUNT_W-1:0] column_count_r;
  logic [SHELL_W-1:0] shell_number_r;
  logic [AMT_W-1:0]   rotate_amount_r;

  cfg_reg_t   reg_sel;
  logic       cfg_wr;
  cfg_t       cfg;
  store_req_t store_req;
  ring_req_t  ring_req;
  word_t      store_rdata;
  word_t      ring_rdata;
  mod_req_t   mod_req;
  mod_rsp_t   mod_rsp;

  assign reg_sel = cfg_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register file; written on the APB access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r     <= COUNT_W'(16);
      column_count_r  <= COUNT_W'(16);
      shell_number_r  <= SHELL_W'(1);
      rotate_amount_r <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ROWS:   row_count_r     <= pwdata[COUNT_W-1:0];
        REG_COLS:   column_count_r  <= pwdata[COUNT_W-1:0];
        REG_SHELL:  shell_number_r  <= pwdata[SHELL_W-1:0];
        REG_AMOUNT: rotate_amount_r <= pwdata[AMT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROWS:   prdata = CFG_DW'(row_count_r);
      REG_COLS:   prdata = CFG_DW'(column_count_r);
      REG_SHELL:  prdata = CFG_DW'(shell_number_r);
      REG_AMOUNT: prdata = CFG_DW'(rotate_amount_r);
      default:    prdata = '0;
    endcase
  end

  // Saturate oversized dimensions to the store size
  always_comb begin
    cfg.rows   = (int'(row_count_r) > MAX_DIM) ? EFF_W'(MAX_DIM) : EFF_W'(row_count_r);
    cfg.cols   = (int'(column_count_r) > MAX_DIM) ? EFF_W'(MAX_DIM)
                                                  : EFF_W'(column_count_r);
    cfg.shell  = shell_number_r;
    cfg.amount = rotate_amount_r;
  end

  mrr_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_row_index    (in_row_index),
    .in_column_index (in_column_index),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .store_req       (store_req),
    .store_rdata     (store_rdata),
    .ring_req        (ring_req),
    .ring_rdata      (ring_rdata),
    .mod_req         (mod_req),
    .mod_rsp         (mod_rsp)
  );

  // Matrix elements, row-major
  mrr_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (store_req.we),
    .waddr (store_req.waddr),
    .wdata (store_req.wdata),
    .re    (store_req.re),
    .raddr (store_req.raddr),
    .rdata (store_rdata)
  );

  // Scratch copy of one ring, already placed at its rotated positions
  mrr_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_req.we),
    .waddr (ring_req.waddr),
    .wdata (ring_req.wdata),
    .re    (ring_req.re),
    .raddr (ring_req.raddr),
    .rdata (ring_rdata)
  );

  mrr_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

endmodule

@@ tb/sv/matrix_ring_rotate_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_ring_rotate_core_tb
// Self-checking bench for the matrix ring rotator. Fills the whole matrix,
// runs directed corner cases (value extremes, every action, out-of-range
// coordinates, degenerate and absent rings, saturated dimensions, extreme
// rotate amounts), then random phases, each under a fresh register setting.
// A mirror of the matrix predicts every result beat and the monitor compares
// the beats in order.
// ----------------------------------------------------------------------------
module matrix_ring_rotate_core_tb;
  import mrr_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int SETTLE       = 4;    // idle cycles before a register write
  localparam int DRAIN        = 40;   // cycles watched for stray beats at the end
  localparam int PHASES       = 13;
  localparam int PHASE_BEATS  = 105;

  // One command beat as the driver presents it, with the idle cycles before it
  typedef struct {
    action_t             act;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [VALUE_W-1:0]  value;
    int                  gap;
  } command_t;

  // One result beat the block owes
  typedef struct {
    logic [VALUE_W-1:0]  value;
    status_t             status;
  } answer_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_action;
  logic [COORD_W-1:0] in_row_index;
  logic [COORD_W-1:0] in_column_index;
  logic [VALUE_W-1:0] in_write_value;
  logic               out_valid;
  logic [VALUE_W-1:0] out_read_value;
  logic [1:0]         out_status;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [CFG_AW-1:0]  paddr;
  logic [CFG_DW-1:0]  pwdata;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  command_t pending_beats[$];
  answer_t  owed_answers[$];

  // Mirror of the block: matrix contents and register values
  word_t              mirror_matrix [STORE_DEPTH];
  logic [COUNT_W-1:0] mirror_rows;
  logic [COUNT_W-1:0] mirror_cols;
  logic [SHELL_W-1:0] mirror_shell;
  logic [AMT_W-1:0]   mirror_amount;

  int error_count;
  int cycle_count;
  bit beat_taken;
  bit gaps_on;

  matrix_ring_rotate_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_row_index    (in_row_index),
    .in_column_index (in_column_index),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk = 1'b1;
    #(HALF_PERIOD);
    clk = 1'b0;
    #(HALF_PERIOD);
  end

  // Watchdog: end the run if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    error_count++;
  endtask

  // Rows or columns in use; a count beyond the matrix saturates
  function automatic int dim_in_use(input logic [COUNT_W-1:0] count);
    return (count > MAX_DIM) ? MAX_DIM : int'(count);
  endfunction

  // Rotate the configured ring of the mirror; return the status it earns
  task automatic turn_mirror_ring(output status_t st);
    int                 rows, cols, s, base, h, w, n, m, k, q, r, c;
    longint             amt;
    int                 spot [RING_DEPTH];
    word_t              saved [RING_DEPTH];
    rows = dim_in_use(mirror_rows);
    cols = dim_in_use(mirror_cols);
    s    = int'(mirror_shell);
    base = s - 1;
    h    = rows - 2 * s + 1;
    w    = cols - 2 * s + 1;
    if (s == 0 || h < 1 || w < 1 || 2 * (h + w) > RING_DEPTH) begin
      st = STAT_DEGEN;
    end else begin
      n   = 2 * (h + w);
      amt = longint'($signed(mirror_amount));
      m   = int'(amt % n);
      if (m < 0) m += n;
      // Walk counterclockwise from the top-left corner: left wall down,
      // bottom row right, right wall up, top row back left
      for (k = 0; k < n; k++) begin
        if (k <= h) begin
          r = base + k;
          c = base;
        end else if (k <= h + w) begin
          r = base + h;
          c = base + k - h;
        end else if (k <= 2 * h + w) begin
          q = k - h - w;
          r = base + h - q;
          c = base + w;
        end else begin
          q = k - 2 * h - w;
          r = base;
          c = base + w - q;
        end
        spot[k]  = r * MAX_DIM + c;
        saved[k] = mirror_matrix[spot[k]];
      end
      for (k = 0; k < n; k++) mirror_matrix[spot[k]] = saved[(k - m + n) % n];
      st = STAT_OK;
    end
  endtask

  // Work out the answer to one accepted beat and update the mirror
  task automatic predict_answer(input command_t cmd, output answer_t ans);
    ans.value  = '0;
    ans.status = STAT_OK;
    case (cmd.act)
      ACT_WRITE, ACT_READ: begin
        if (int'(cmd.row) >= dim_in_use(mirror_rows) ||
            int'(cmd.col) >= dim_in_use(mirror_cols)) begin
          ans.status = STAT_RANGE;
        end else if (cmd.act == ACT_WRITE) begin
          mirror_matrix[int'(cmd.row) * MAX_DIM + int'(cmd.col)] = cmd.value;
        end else begin
          ans.value = mirror_matrix[int'(cmd.row) * MAX_DIM + int'(cmd.col)];
        end
      end
      ACT_ROTATE: turn_mirror_ring(ans.status);
      default: ;
    endcase
  endtask

  // Input-side sampler: catch each accepted command beat and predict it
  always @(posedge clk) begin
    command_t cmd;
    answer_t  ans;
    beat_taken = rst_n && start && !busy;
    if (beat_taken) begin
      cmd.act   = action_t'(in_action);
      cmd.row   = in_row_index;
      cmd.col   = in_column_index;
      cmd.value = in_write_value;
      cmd.gap   = 0;
      predict_answer(cmd, ans);
      owed_answers.push_back(ans);
    end
  end

  // Driver: hold start until the beat is taken, idle out the gap, then
  // advance to the next pending command
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !beat_taken) begin
      // hold the current beat
    end else if (pending_beats.size() == 0) begin
      start <= 1'b0;
    end else if (pending_beats[0].gap > 0) begin
      start <= 1'b0;
      pending_beats[0].gap--;
    end else begin
      start           <= 1'b1;
      in_action       <= pending_beats[0].act;
      in_row_index    <= pending_beats[0].row;
      in_column_index <= pending_beats[0].col;
      in_write_value  <= pending_beats[0].value;
      void'(pending_beats.pop_front());
    end
  end

  // Monitor: every result beat must match the oldest owed answer
  always @(posedge clk) begin
    answer_t ans;
    if (rst_n && out_valid) begin
      if (owed_answers.size() == 0) begin
        report_mismatch($sformatf("result beat with none owed: value %h status %0d",
                                  out_read_value, out_status));
      end else begin
        ans = owed_answers.pop_front();
        if (out_read_value !== ans.value)
          report_mismatch($sformatf("read_value %h, want %h", out_read_value, ans.value));
        if (out_status !== ans.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, ans.status));
      end
    end
  end

  // Mostly short gaps, a few long ones; none at all when gaps are off
  task automatic queue_beat(input action_t act, input int row, input int col,
                            input logic [VALUE_W-1:0] value);
    command_t cmd;
    int       pick;
    pick      = $urandom_range(0, 99);
    cmd.act   = act;
    cmd.row   = COORD_W'(row);
    cmd.col   = COORD_W'(col);
    cmd.value = value;
    if (!gaps_on || pick < 55) cmd.gap = 0;
    else if (pick < 90)        cmd.gap = $urandom_range(1, 3);
    else                       cmd.gap = $urandom_range(8, 40);
    pending_beats.push_back(cmd);
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || start || owed_answers.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ROWS:   mirror_rows   = data[COUNT_W-1:0];
      REG_COLS:   mirror_cols   = data[COUNT_W-1:0];
      REG_SHELL:  mirror_shell  = data[SHELL_W-1:0];
      REG_AMOUNT: mirror_amount = data[AMT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drain the block, then load all four registers
  task automatic set_config(input int rows, input int cols, input int shell,
                            input logic [AMT_W-1:0] amount);
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    write_register(REG_ROWS,   CFG_DW'(rows));
    write_register(REG_COLS,   CFG_DW'(cols));
    write_register(REG_SHELL,  CFG_DW'(shell));
    write_register(REG_AMOUNT, CFG_DW'(amount));
  endtask

  // Random coordinate, mostly inside the area in use
  function automatic int pick_coord(input int in_use);
    if (in_use > 0 && $urandom_range(0, 9) < 7) return $urandom_range(0, in_use - 1);
    return $urandom_range(0, MAX_DIM - 1);
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return $urandom_range(MAX_DIM + 1, 31);
      2, 3:    return MAX_DIM;
      4:       return 1;
      default: return $urandom_range(2, MAX_DIM);
    endcase
  endfunction

  function automatic logic [AMT_W-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0:          return 32'h8000_0000;
      1:          return 32'h7fff_ffff;
      2, 3, 4, 5: return AMT_W'($urandom_range(0, 160) - 80);
      default:    return $urandom;
    endcase
  endfunction

  initial begin
    int rows, cols, shell, narrow, pick, p, i, r, c;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_action       = ACT_NONE;
    in_row_index    = '0;
    in_column_index = '0;
    in_write_value  = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    error_count     = 0;
    cycle_count     = 0;
    beat_taken      = 1'b0;
    gaps_on         = 1'b1;
    mirror_rows     = COUNT_W'(16);
    mirror_cols     = COUNT_W'(16);
    mirror_shell    = SHELL_W'(1);
    mirror_amount   = '0;
    for (i = 0; i < STORE_DEPTH; i++) mirror_matrix[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill every entry under the reset dimensions so no later read or
    // rotate can touch an entry that was never written
    for (r = 0; r < MAX_DIM; r++)
      for (c = 0; c < MAX_DIM; c++) queue_beat(ACT_WRITE, r, c, $urandom);

    // Value extremes at the corners, read them back, an unused action and
    // a rotate by zero
    queue_beat(ACT_WRITE, 0, 0, 32'h7fff_ffff);
    queue_beat(ACT_WRITE, 15, 15, 32'h8000_0000);
    queue_beat(ACT_WRITE, 0, 15, 32'hffff_ffff);
    queue_beat(ACT_WRITE, 15, 0, 32'h0000_0000);
    queue_beat(ACT_READ, 0, 0, '0);
    queue_beat(ACT_READ, 15, 15, '0);
    queue_beat(ACT_READ, 0, 15, '0);
    queue_beat(ACT_READ, 15, 0, '0);
    queue_beat(ACT_NONE, 15, 15, 32'hffff_ffff);
    queue_beat(ACT_ROTATE, 0, 0, '0);

    // Outer ring by the most negative amount
    set_config(16, 16, 1, 32'h8000_0000);
    queue_beat(ACT_ROTATE, 0, 0, '0);
    queue_beat(ACT_READ, 1, 0, '0);

    // Innermost two by two ring by the most positive amount
    set_config(16, 16, 8, 32'h7fff_ffff);
    queue_beat(ACT_ROTATE, 0, 0, '0);
    queue_beat(ACT_READ, 7, 7, '0);

    // Small rectangle, negative turn, coordinates just outside it
    set_config(3, 5, 1, 32'hffff_ffff);
    queue_beat(ACT_ROTATE, 0, 0, '0);
    queue_beat(ACT_WRITE, 3, 0, 32'h1234_5678);
    queue_beat(ACT_READ, 0, 5, '0);
    queue_beat(ACT_READ, 2, 4, '0);

    // A single row and a single column: both rings are degenerate
    set_config(1, 16, 1, 5);
    queue_beat(ACT_ROTATE, 0, 0, '0);
    set_config(16, 1, 1, 5);
    queue_beat(ACT_ROTATE, 0, 0, '0);

    // Zero counts and shell zero: nothing is in range, no ring
    set_config(0, 0, 0, 7);
    queue_beat(ACT_ROTATE, 0, 0, '0);
    queue_beat(ACT_WRITE, 0, 0, 32'h5555_aaaa);

    // Counts beyond the matrix saturate; a shell past the center is absent
    set_config(31, 31, 15, 3);
    queue_beat(ACT_WRITE, 15, 15, 32'haaaa_5555);
    queue_beat(ACT_ROTATE, 0, 0, '0);

    // Random phases, each under its own register setting
    for (p = 0; p < PHASES; p++) begin
      rows   = pick_dim();
      cols   = pick_dim();
      narrow = (dim_in_use(COUNT_W'(rows)) < dim_in_use(COUNT_W'(cols))) ?
               dim_in_use(COUNT_W'(rows)) : dim_in_use(COUNT_W'(cols));
      if (narrow >= 2 && $urandom_range(0, 9) < 8) shell = $urandom_range(1, (narrow + 1) / 2);
      else                                         shell = $urandom_range(0, 15);
      set_config(rows, cols, shell, pick_amount());
      gaps_on = ($urandom_range(0, 3) != 0);
      for (i = 0; i < PHASE_BEATS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35)
          queue_beat(ACT_WRITE, pick_coord(dim_in_use(mirror_rows)),
                     pick_coord(dim_in_use(mirror_cols)), $urandom);
        else if (pick < 70)
          queue_beat(ACT_READ, pick_coord(dim_in_use(mirror_rows)),
                     pick_coord(dim_in_use(mirror_cols)), $urandom);
        else if (pick < 93)
          queue_beat(ACT_ROTATE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
        else
          queue_beat(ACT_NONE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
      end
    end

    // Drain, then watch for stray beats
    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (owed_answers.size() != 0)
      report_mismatch($sformatf("%0d result beats never arrived", owed_answers.size()));
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
